// ----- sv/software_timer_pool_defines.svh -----
// ---------------------------------------------------------------------------
// software_timer_pool_defines.svh
// Assertion macros shared by the timer pool RTL.
// ---------------------------------------------------------------------------
`ifndef SOFTWARE_TIMER_POOL_DEFINES_SVH
`define SOFTWARE_TIMER_POOL_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define STP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define STP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/stp_pkg.sv -----
// ---------------------------------------------------------------------------
// stp_pkg
// Shared constants, codes and helpers for the software timer pool.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stp_pkg;

  localparam int SLOT_COUNT     = 8;
  localparam int RESERVED_SLOTS = 2;

  localparam int VAL_W   = 16;
  localparam int CMD_W   = 3;
  localparam int IDX_W   = 6;
  localparam int GRANT_W = 7;
  localparam int TOT_W   = 32;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CNT_W   = $clog2(SLOT_COUNT);

  localparam logic [VAL_W-1:0] FREE_MARK = 16'hFFFF;
  localparam logic [VAL_W-1:0] TPS_RESET = 16'd1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_READ  = 3'd3,
    CMD_LOAD  = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TPS     = 1'b0,
    REG_RUNNING = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_HOLD
  } state_t;

  // The all-ones value marks a free slot, so a delay of all ones is
  // stored one below it.
  function automatic logic [VAL_W-1:0] clamp_delay(input logic [VAL_W-1:0] d);
    logic [VAL_W-1:0] r;
    r = (d == FREE_MARK) ? FREE_MARK - 16'd1 : d;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/stp_cell.sv -----
// ---------------------------------------------------------------------------
// stp_cell
// One countdown slot of the ring; takes its neighbor's value on a shift.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stp_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      shift,
  input  logic [stp_pkg::VAL_W-1:0] d,
  output logic [stp_pkg::VAL_W-1:0] q
);
  import stp_pkg::*;

  logic [VAL_W-1:0] slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= FREE_MARK;
    end else if (shift) begin
      slot <= d;
    end
  end

  assign q = slot;

endmodule

`default_nettype wire

// ----- sv/software_timer_pool.sv -----
// ---------------------------------------------------------------------------
// software_timer_pool
// Pool of 16-bit countdown slots with slot allocation and tick/second totals.
// ---------------------------------------------------------------------------
// Each item is accepted and then makes one full revolution of the slot
// ring before its result is loaded into the output register. During that
// revolution every slot passes once through the single update
// unit at the ring's head. That revolution sets the rate. The result sits
// in an output register, so the next item is accepted as soon as the ring
// is back in place, even while the previous result still waits; only if a
// result is still waiting at the end of the following revolution does the
// block hold. Tick and second totals are updated at acceptance, and the
// result reports the totals after its item. Configuration writes take
// effect at once; a new ticks_per_second is used at the next second reload.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "software_timer_pool_defines.svh"

module software_timer_pool (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [stp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [stp_pkg::CFG_W-1:0]     cfg_data,
  // Input items.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [stp_pkg::CMD_W-1:0]     cmd,
  input  logic [stp_pkg::IDX_W-1:0]     slot_index,
  input  logic [stp_pkg::VAL_W-1:0]     delay_value,
  // Result items.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [stp_pkg::GRANT_W-1:0]   granted_slot,
  output logic [stp_pkg::VAL_W-1:0]     slot_value,
  output logic [stp_pkg::TOT_W-1:0]     seconds_total,
  output logic [stp_pkg::TOT_W-1:0]     ticks_total
);
  import stp_pkg::*;

  localparam logic [GRANT_W-1:0] RSV_EXT   = GRANT_W'(RESERVED_SLOTS);
  localparam logic [GRANT_W-1:0] SLOT_EXT  = GRANT_W'(SLOT_COUNT);
  localparam logic [CNT_W-1:0]   LAST_STEP = CNT_W'(SLOT_COUNT - 1);

  // Configuration registers.
  logic [VAL_W-1:0] ticks_per_second;
  logic             running;

  // Timebase state.
  logic [VAL_W-1:0] second_countdown;
  logic [TOT_W-1:0] second_count;
  logic [TOT_W-1:0] tick_count;

  // Control.
  state_t           state, state_next;
  logic             shift;
  logic             load_out;
  logic             accept;
  logic             out_take;
  logic [CNT_W-1:0] step;

  // The item under work.
  cmd_t             w_cmd;
  logic [IDX_W-1:0] w_idx;
  logic [VAL_W-1:0] w_delay;
  logic             w_live;
  logic [GRANT_W-1:0] w_grant, w_grant_next;
  logic             w_found, w_found_next;
  logic [VAL_W-1:0] w_value, w_value_next;

  // Slot ring.
  logic [VAL_W-1:0] ring_q [SLOT_COUNT];
  logic [VAL_W-1:0] head, head_next;
  logic [GRANT_W-1:0] head_pos;
  logic [GRANT_W-1:0] idx_ext;
  logic             idx_hit;

  logic [VAL_W-1:0] sec_dec;

  // -------------------------------------------------------------------------
  // Configuration port.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TPS_RESET;
      running          <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TPS:     ticks_per_second <= cfg_data;
        REG_RUNNING: running          <= cfg_data[0];
        default:     running          <= running;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer: accept, one ring revolution, then hand over to the output
  // register (or hold while a previous result is still waiting). No item is
  // taken while reset is applied.
  // -------------------------------------------------------------------------
  assign out_take = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    shift      = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid) begin
          state_next = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        shift = 1'b1;
        if (step == LAST_STEP) begin
          if (out_take) begin
            load_out   = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_take) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // Slot ring. Each shift moves every slot one cell toward the head; the
  // head slot goes through the update unit and re-enters at the tail. After
  // SLOT_COUNT shifts every slot is back in its home cell.
  // -------------------------------------------------------------------------
  for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_ring
    logic [VAL_W-1:0] cell_d;
    if (k == SLOT_COUNT - 1) begin : g_tail
      assign cell_d = head_next;
    end else begin : g_mid
      assign cell_d = ring_q[k+1];
    end
    stp_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (cell_d),
      .q     (ring_q[k])
    );
  end

  assign head     = ring_q[0];
  assign head_pos = GRANT_W'(step);
  assign idx_ext  = {1'b0, w_idx};
  assign idx_hit  = (idx_ext == head_pos);

  // Update unit at the head of the ring.
  always_comb begin
    head_next    = head;
    w_grant_next = w_grant;
    w_found_next = w_found;
    w_value_next = w_value;
    case (w_cmd)
      CMD_TICK: begin
        if (w_live && head != '0 && head != FREE_MARK) begin
          head_next = head - 16'd1;
        end
      end
      CMD_START: begin
        // Slots pass the head in index order, so the first free one seen
        // is the lowest free slot above the reserved range.
        if (!w_found && head_pos >= RSV_EXT && head == FREE_MARK) begin
          head_next    = clamp_delay(w_delay);
          w_grant_next = head_pos;
          w_found_next = 1'b1;
        end
      end
      CMD_STOP: begin
        if (idx_hit && idx_ext >= RSV_EXT) begin
          head_next = FREE_MARK;
        end
      end
      CMD_READ: begin
        if (idx_hit) begin
          w_value_next = head;
        end
      end
      CMD_LOAD: begin
        if (idx_hit && idx_ext < RSV_EXT) begin
          head_next = clamp_delay(w_delay);
        end
      end
      default: begin
        head_next = head;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      w_cmd   <= cmd_t'(cmd);
      w_idx   <= slot_index;
      w_delay <= delay_value;
      w_live  <= running;
      w_grant <= SLOT_EXT;
      w_found <= 1'b0;
      w_value <= '0;
      step    <= '0;
    end else if (shift) begin
      w_grant <= w_grant_next;
      w_found <= w_found_next;
      w_value <= w_value_next;
      step    <= step + CNT_W'(1);
    end
  end

  // -------------------------------------------------------------------------
  // Timebase totals, advanced when a tick is accepted while running.
  // -------------------------------------------------------------------------
  assign sec_dec = second_countdown - 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      second_countdown <= TPS_RESET;
      second_count     <= '0;
      tick_count       <= '0;
    end else if (accept && cmd == CMD_TICK && running) begin
      tick_count <= tick_count + 32'd1;
      if (sec_dec == '0) begin
        second_count     <= second_count + 32'd1;
        second_countdown <= (ticks_per_second == '0) ? 16'd1 : ticks_per_second;
      end else begin
        second_countdown <= sec_dec;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Output register.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      granted_slot  <= (state == ST_SWEEP) ? w_grant_next : w_grant;
      slot_value    <= (state == ST_SWEEP) ? w_value_next : w_value;
      seconds_total <= second_count;
      ticks_total   <= tick_count;
    end
  end

  // -------------------------------------------------------------------------
  // Assertions.
  // -------------------------------------------------------------------------
  `STP_ASSERT_NEXT(a_accept_sweeps, accept, state == ST_SWEEP,
    "accepted item did not start a ring revolution")
  `STP_ASSERT_NEXT(a_sweep_ends, (state == ST_SWEEP) && (step == LAST_STEP),
    state != ST_SWEEP, "ring revolution ran past the last slot")
  `STP_ASSERT_NOW(a_grant_range, out_valid,
    (granted_slot == SLOT_EXT) || ((granted_slot >= RSV_EXT) && (granted_slot < SLOT_EXT)),
    "granted slot outside the allocatable range")
  `STP_ASSERT_NEXT(a_tick_step, accept && (cmd == CMD_TICK) && running,
    tick_count == $past(tick_count) + 32'd1, "tick total did not advance by one")

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the software timer pool: a directed table, then
// random command traffic under several timebase settings, with every result
// compared against a cycle-free prediction of the pool or a hand-written value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import stp_pkg::*;

  // Cycles without any accepted item before the run is declared hung. The
  // slowest legal gap is a long sender pause plus a long receiver stall plus
  // one slot-ring revolution.
  localparam int WATCHDOG_LIMIT = 2000;
  // Cycles allowed after the last result before a register write or the
  // final verdict; one revolution of the slot ring plus a small margin.
  localparam int SETTLE_CYCLES = SLOT_COUNT + 4;

  // Command codes 5 to 7 are unused by the block and must act as no-ops.
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  // Grant value that means no slot was claimed.
  localparam logic [GRANT_W-1:0] NONE_GRANTED = GRANT_W'(SLOT_COUNT);

  typedef struct packed {
    logic [GRANT_W-1:0] granted;
    logic [VAL_W-1:0]   value;
    logic [TOT_W-1:0]   secs;
    logic [TOT_W-1:0]   ticks;
  } pool_result_t;

  // One row of the directed table. Rows with want_fixed set carry their
  // expected result written out by hand; the others use the predictor.
  typedef struct {
    logic [CMD_W-1:0] op;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] delay;
    bit               want_fixed;
    pool_result_t     want;
  } stim_row_t;

  // Clock, reset and all block inputs start at known values.
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TPS;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     cmd = CMD_READ;
  logic [IDX_W-1:0]     slot_index = '0;
  logic [VAL_W-1:0]     delay_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [GRANT_W-1:0]   granted_slot;
  logic [VAL_W-1:0]     slot_value;
  logic [TOT_W-1:0]     seconds_total;
  logic [TOT_W-1:0]     ticks_total;

  // Predicted pool state, kept in step with every accepted item.
  logic [VAL_W-1:0] slot_q [SLOT_COUNT];
  logic [VAL_W-1:0] sec_countdown_q;
  logic [TOT_W-1:0] sec_count_q;
  logic [TOT_W-1:0] tick_count_q;
  logic [VAL_W-1:0] tps_q;
  logic             running_q;

  pool_result_t predicted_results[$];
  stim_row_t    directed_rows[$];
  int           mismatches = 0;
  int           idle_cycles = 0;
  bit           valid_up = 1'b0;

  software_timer_pool u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .slot_index    (slot_index),
    .delay_value   (delay_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .granted_slot  (granted_slot),
    .slot_value    (slot_value),
    .seconds_total (seconds_total),
    .ticks_total   (ticks_total)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Idle length used by both sides: mostly none or short, now and then a
  // stretch long enough to span several revolutions of the slot ring.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // A delay of all ones would read as a free slot, so it is kept one lower.
  function automatic logic [VAL_W-1:0] stored_delay(input logic [VAL_W-1:0] d);
    return (d == FREE_MARK) ? FREE_MARK - 1'b1 : d;
  endfunction

  function automatic pool_result_t typed_result(input int g, input logic [VAL_W-1:0] v,
                                                input int s, input int t);
    pool_result_t r;
    r.granted = GRANT_W'(g);
    r.value   = v;
    r.secs    = TOT_W'(s);
    r.ticks   = TOT_W'(t);
    return r;
  endfunction

  // Applies one command to the predicted pool and returns the result it
  // should produce. Totals in the result are the ones after the command.
  function automatic pool_result_t advance_pool(input logic [CMD_W-1:0] op,
                                                input logic [IDX_W-1:0] ix,
                                                input logic [VAL_W-1:0] d);
    pool_result_t r;
    bit           claimed;
    r.granted = NONE_GRANTED;
    r.value   = '0;
    claimed   = 1'b0;
    case (op)
      CMD_TICK: begin
        // A suspended timebase leaves every counter untouched.
        if (running_q) begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (slot_q[i] != '0 && slot_q[i] != FREE_MARK) slot_q[i] = slot_q[i] - 1'b1;
          end
          sec_countdown_q = sec_countdown_q - 1'b1;
          if (sec_countdown_q == '0) begin
            sec_count_q = sec_count_q + 1'b1;
            // A zero setting reloads as one tick per second.
            sec_countdown_q = (tps_q == '0) ? VAL_W'(1) : tps_q;
          end
          tick_count_q = tick_count_q + 1'b1;
        end
      end
      CMD_START: begin
        for (int i = RESERVED_SLOTS; i < SLOT_COUNT; i++) begin
          if (!claimed && slot_q[i] == FREE_MARK) begin
            slot_q[i] = stored_delay(d);
            r.granted = GRANT_W'(i);
            claimed   = 1'b1;
          end
        end
      end
      CMD_STOP: begin
        if (ix >= RESERVED_SLOTS && ix < SLOT_COUNT) slot_q[ix[CNT_W-1:0]] = FREE_MARK;
      end
      CMD_READ: begin
        if (ix < SLOT_COUNT) r.value = slot_q[ix[CNT_W-1:0]];
      end
      CMD_LOAD: begin
        if (ix < RESERVED_SLOTS) slot_q[ix[CNT_W-1:0]] = stored_delay(d);
      end
      default: begin
      end
    endcase
    r.secs  = sec_count_q;
    r.ticks = tick_count_q;
    return r;
  endfunction

  task automatic add_row(input logic [CMD_W-1:0] op, input logic [IDX_W-1:0] ix,
                         input logic [VAL_W-1:0] d, input bit fixed, input pool_result_t want);
    stim_row_t row;
    row.op         = op;
    row.idx        = ix;
    row.delay      = d;
    row.want_fixed = fixed;
    row.want       = want;
    directed_rows.push_back(row);
  endtask

  // Presents one item after a random gap and holds it until accepted. The
  // valid line is lowered only when a gap follows, so it never gets two
  // updates in the same time step.
  task automatic send_item(input logic [CMD_W-1:0] op, input logic [IDX_W-1:0] ix,
                           input logic [VAL_W-1:0] d, input bit fixed, input pool_result_t want);
    int           gap;
    pool_result_t predicted;
    gap = gap_len();
    if (gap > 0) begin
      if (valid_up) in_valid <= 1'b0;
      valid_up = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    valid_up    = 1'b1;
    cmd         <= op;
    slot_index  <= ix;
    delay_value <= d;
    do @(posedge clk); while (!in_ready);
    predicted = advance_pool(op, ix, d);
    predicted_results.push_back(fixed ? want : predicted);
  endtask

  // Stops sending and waits until every predicted result has been seen. Valid
  // drops before the wait for the clock, so a following send never updates
  // valid twice in one step.
  task automatic drain_results();
    if (valid_up) in_valid <= 1'b0;
    valid_up = 1'b0;
    do @(posedge clk); while (predicted_results.size() != 0);
  endtask

  // Writes both timebase registers one after the other while the pool is
  // quiet. The predictor takes the new values at the same point.
  task automatic set_timebase(input logic [VAL_W-1:0] tps, input logic run);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TPS;
    cfg_data  <= tps;
    @(posedge clk);
    cfg_index <= REG_RUNNING;
    cfg_data  <= CFG_W'(run);
    @(posedge clk);
    cfg_we    <= 1'b0;
    tps_q     = tps;
    running_q = run;
  endtask

  // Random command with a given share of ticks. Indexes mostly land in or
  // just past the pool; delays are mostly short so slots actually expire.
  task automatic random_item(input int tick_pct);
    logic [CMD_W-1:0] op;
    logic [IDX_W-1:0] ix;
    logic [VAL_W-1:0] d;
    int               r;
    r = $urandom_range(0, 99);
    if (r < tick_pct) begin
      op = CMD_TICK;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 28)      op = CMD_START;
      else if (r < 48) op = CMD_STOP;
      else if (r < 76) op = CMD_READ;
      else if (r < 94) op = CMD_LOAD;
      else             op = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    end
    if ($urandom_range(0, 4) == 0) ix = IDX_W'($urandom_range(0, 63));
    else                           ix = IDX_W'($urandom_range(0, SLOT_COUNT + 1));
    r = $urandom_range(0, 99);
    if (r < 70)      d = VAL_W'($urandom_range(0, 24));
    else if (r < 85) d = VAL_W'($urandom_range(0, 65535));
    else if (r < 95) begin
      case ($urandom_range(0, 3))
        0:       d = FREE_MARK;
        1:       d = FREE_MARK - 1'b1;
        2:       d = '0;
        default: d = VAL_W'(1);
      endcase
    end else begin
      d = VAL_W'($urandom_range(25, 400));
    end
    send_item(op, ix, d, 1'b0, '0);
  endtask

  // Result checker: each accepted result is matched, field by field, with
  // the oldest prediction still waiting.
  always @(posedge clk) begin
    pool_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (predicted_results.size() == 0) begin
        $display("%0t: unexpected result granted=%0d value=%h secs=%0d ticks=%0d",
                 $time, granted_slot, slot_value, seconds_total, ticks_total);
        mismatches++;
      end else begin
        want = predicted_results.pop_front();
        if (granted_slot !== want.granted) begin
          $display("%0t: granted_slot expected %0d actual %0d", $time, want.granted,
                   granted_slot);
          mismatches++;
        end
        if (slot_value !== want.value) begin
          $display("%0t: slot_value expected %h actual %h", $time, want.value, slot_value);
          mismatches++;
        end
        if (seconds_total !== want.secs) begin
          $display("%0t: seconds_total expected %0d actual %0d", $time, want.secs,
                   seconds_total);
          mismatches++;
        end
        if (ticks_total !== want.ticks) begin
          $display("%0t: ticks_total expected %0d actual %0d", $time, want.ticks,
                   ticks_total);
          mismatches++;
        end
      end
    end
  end

  // Any accepted item on either side counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver pacing: stretches of ready broken by stalls of random length,
  // with the occasional long stretch of no stalls at all.
  initial begin : sink_pacing
    int seg_left;
    int stall;
    seg_left = 0;
    forever begin
      @(posedge clk);
      if (seg_left > 0) begin
        seg_left--;
      end else if (out_ready) begin
        stall = gap_len();
        if (stall > 0) begin
          out_ready <= 1'b0;
          seg_left = stall - 1;
        end else begin
          seg_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(0, 30);
        end
      end else begin
        out_ready <= 1'b1;
        seg_left = $urandom_range(0, 30);
      end
    end
  end

  initial begin : stimulus
    int n;
    // Predictor starts from the reset state of the pool.
    for (int i = 0; i < SLOT_COUNT; i++) slot_q[i] = FREE_MARK;
    sec_countdown_q = TPS_RESET;
    sec_count_q     = '0;
    tick_count_q    = '0;
    tps_q           = TPS_RESET;
    running_q       = 1'b1;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. The first rows follow straight from reset: every slot
    // free, totals at zero, first claim lands just past the reserved slots.
    add_row(CMD_READ, 6'd0, 16'h0000, 1'b1, typed_result(SLOT_COUNT, FREE_MARK, 0, 0));
    add_row(CMD_READ, 6'd63, 16'h0000, 1'b1, typed_result(SLOT_COUNT, 16'h0000, 0, 0));
    // A delay of all ones is kept one lower so the slot does not read free.
    add_row(CMD_START, 6'd0, 16'hFFFF, 1'b1, typed_result(RESERVED_SLOTS, 16'h0000, 0, 0));
    add_row(CMD_READ, 6'd2, 16'h0000, 1'b1, typed_result(SLOT_COUNT, 16'hFFFE, 0, 0));
    add_row(CMD_SPARE_HI, 6'd63, 16'hFFFF, 1'b1, typed_result(SLOT_COUNT, 16'h0000, 0, 0));
    add_row(CMD_TICK, 6'd0, 16'h0000, 1'b1, typed_result(SLOT_COUNT, 16'h0000, 0, 1));
    add_row(CMD_READ, 6'd2, 16'h0000, 1'b1, typed_result(SLOT_COUNT, 16'hFFFD, 0, 1));
    // Zero and one tick delays: an expired slot stays at zero on later ticks.
    add_row(CMD_START, 6'd0, 16'h0000, 1'b0, '0);
    add_row(CMD_START, 6'd0, 16'h0001, 1'b0, '0);
    add_row(CMD_TICK, 6'd0, 16'h0000, 1'b0, '0);
    add_row(CMD_READ, 6'd3, 16'h0000, 1'b0, '0);
    add_row(CMD_READ, 6'd4, 16'h0000, 1'b0, '0);
    // Loads reach only the reserved slots; other indexes are ignored.
    add_row(CMD_LOAD, 6'd0, 16'hFFFF, 1'b0, '0);
    add_row(CMD_LOAD, 6'd1, 16'h0000, 1'b0, '0);
    add_row(CMD_LOAD, 6'd7, 16'h0005, 1'b0, '0);
    add_row(CMD_LOAD, 6'd63, 16'h1234, 1'b0, '0);
    add_row(CMD_READ, 6'd0, 16'h0000, 1'b0, '0);
    // Stops of a reserved or out-of-range slot are ignored.
    add_row(CMD_STOP, 6'd1, 16'h0000, 1'b0, '0);
    add_row(CMD_STOP, 6'd63, 16'h0000, 1'b0, '0);
    add_row(CMD_STOP, 6'd2, 16'h0000, 1'b0, '0);
    // Refill the pool until no slot is left, then one claim more.
    add_row(CMD_START, 6'd0, 16'h8000, 1'b0, '0);
    add_row(CMD_START, 6'd0, 16'h7FFF, 1'b0, '0);
    add_row(CMD_START, 6'd0, 16'h00FF, 1'b0, '0);
    add_row(CMD_START, 6'd0, 16'hFFFE, 1'b0, '0);
    add_row(CMD_START, 6'd0, 16'h0003, 1'b0, '0);
    add_row(CMD_SPARE_LO, 6'd0, 16'h0000, 1'b0, '0);
    add_row(CMD_READ, 6'(SLOT_COUNT), 16'h0000, 1'b0, '0);
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].delay,
                directed_rows[i].want_fixed, directed_rows[i].want);
    end
    drain_results();

    // One tick per second. The first reload only comes after the reset
    // countdown runs out, so this phase is mostly ticks and lasts until a
    // couple of dozen seconds have passed at the new rate.
    set_timebase(VAL_W'(1), 1'b1);
    n = 0;
    while (sec_count_q < 25 && n < 4000) begin
      random_item(85);
      n++;
      // Sender holds off once until every outstanding result is back.
      if (n == 300) drain_results();
    end
    drain_results();

    // A zero setting reloads as one tick per second.
    set_timebase(VAL_W'(0), 1'b1);
    repeat (160) random_item(50);
    drain_results();

    // Suspended timebase: ticks change nothing while commands still act.
    set_timebase(VAL_W'(3), 1'b0);
    repeat (120) random_item(50);
    drain_results();

    set_timebase(VAL_W'(2), 1'b1);
    repeat (160) random_item(50);
    drain_results();

    // Largest setting last, since after its first reload no second passes.
    set_timebase(FREE_MARK, 1'b1);
    repeat (160) random_item(50);
    drain_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
